// ===== src/interval_region_classifier_top_defines.svh =====
// Assertion macros for the interval region classifier
`ifndef INTERVAL_REGION_CLASSIFIER_TOP_DEFINES_SVH
`define INTERVAL_REGION_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define IRC_ASSERT_NOW(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("irc check failed");

// next-cycle implication, held off during reset
`define IRC_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("irc check failed");

// next-cycle implication, checked through reset
`define IRC_ASSERT_ALWAYS(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) (a) |=> (c)) \
        else $error("irc reset check failed");

`endif

// ===== src/irc_pkg.sv =====
package irc_pkg;

    localparam int POS_W = 31;
    localparam int COV_W = 46;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] LOC_INSIDE  = 2'd0;
    localparam logic [1:0] LOC_OUTSIDE = 2'd1;
    localparam logic [1:0] LOC_BORDER  = 2'd2;
    localparam logic [1:0] LOC_OFFCTG  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FLIPPED  = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_UNSORTED = 3'd3;
    localparam logic [2:0] ST_OVERLAP  = 3'd4;
    localparam logic [2:0] ST_ABUT     = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;
    localparam logic [2:0] ST_BADQ     = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_ADD_CHK,
        S_Q_FIRST,
        S_Q_LAST,
        S_UB,
        S_UB_CMP,
        S_LB,
        S_LB_CMP,
        S_Q_LI,
        S_Q_SI,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_LAST,
        RD_MID,
        RD_LI,
        RD_SI
    } t_rd_sel;

    typedef struct packed {
        logic       load;
        t_rd_sel    rd_sel;
        logic       res_set;
        logic [1:0] res_loc;
        logic [2:0] res_status;
        logic       write;
        logic       clear;
        logic       init_search;
        logic       ub_step;
        logic       ub_done;
        logic       lb_step;
        logic       latch_li;
        logic       publish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       flipped;
        logic       zero;
        logic       ctg_bad;
        logic       n_zero;
        logic       full;
        logic       unsorted;
        logic       overlap;
        logic       abut;
        logic       first_out;
        logic       last_out;
        logic       lo_lt_hi;
        logic       si_neg;
        logic       li_ge_n;
        logic       li_eq_si;
        logic       li_eq_si1;
        logic       ins_border;
        logic       gap_out;
        logic       out_free;
    } t_stat;

endpackage

// ===== src/irc_ctrl.sv =====
module irc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  irc_pkg::t_stat i_stat,
    output irc_pkg::t_cmd  o_cmd
);

    irc_pkg::t_state r_state;
    irc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.rd_sel = irc_pkg::RD_MID;
        o_stall = (r_state != irc_pkg::S_IDLE);
        case (r_state)
            irc_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = irc_pkg::S_DISP;
                end
            end
            irc_pkg::S_DISP: begin
                n_state = irc_pkg::S_OUT;
                o_cmd.res_set = 1'b1;
                o_cmd.res_loc = irc_pkg::LOC_INSIDE;
                o_cmd.res_status = irc_pkg::ST_OK;
                case (i_stat.op)
                    irc_pkg::OP_ADD: begin
                        if (i_stat.flipped) begin
                            o_cmd.res_status = irc_pkg::ST_FLIPPED;
                        end else if (i_stat.zero) begin
                            o_cmd.res_status = irc_pkg::ST_ZERO;
                        end else if (i_stat.ctg_bad) begin
                            o_cmd.res_status = irc_pkg::ST_FULL;
                        end else if (!i_stat.n_zero) begin
                            o_cmd.res_set = 1'b0;
                            o_cmd.rd_sel = irc_pkg::RD_LAST;
                            n_state = irc_pkg::S_ADD_CHK;
                        end else begin
                            o_cmd.write = 1'b1;
                        end
                    end
                    irc_pkg::OP_QUERY: begin
                        if (i_stat.flipped) begin
                            o_cmd.res_status = irc_pkg::ST_BADQ;
                        end else if (i_stat.ctg_bad || i_stat.n_zero) begin
                            o_cmd.res_loc = irc_pkg::LOC_OFFCTG;
                        end else begin
                            o_cmd.res_set = 1'b0;
                            o_cmd.rd_sel = irc_pkg::RD_ZERO;
                            n_state = irc_pkg::S_Q_FIRST;
                        end
                    end
                    irc_pkg::OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                        o_cmd.res_status = irc_pkg::ST_BADQ;
                    end
                endcase
            end
            irc_pkg::S_ADD_CHK: begin
                n_state = irc_pkg::S_OUT;
                o_cmd.res_set = 1'b1;
                if (i_stat.unsorted) begin
                    o_cmd.res_status = irc_pkg::ST_UNSORTED;
                end else if (i_stat.overlap) begin
                    o_cmd.res_status = irc_pkg::ST_OVERLAP;
                end else if (i_stat.full) begin
                    o_cmd.res_status = irc_pkg::ST_FULL;
                end else begin
                    o_cmd.write = 1'b1;
                    o_cmd.res_status = i_stat.abut ? irc_pkg::ST_ABUT : irc_pkg::ST_OK;
                end
            end
            irc_pkg::S_Q_FIRST: begin
                if (i_stat.first_out) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_loc = irc_pkg::LOC_OUTSIDE;
                    n_state = irc_pkg::S_OUT;
                end else begin
                    o_cmd.rd_sel = irc_pkg::RD_LAST;
                    n_state = irc_pkg::S_Q_LAST;
                end
            end
            irc_pkg::S_Q_LAST: begin
                if (i_stat.last_out) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_loc = irc_pkg::LOC_OUTSIDE;
                    n_state = irc_pkg::S_OUT;
                end else begin
                    o_cmd.init_search = 1'b1;
                    n_state = irc_pkg::S_UB;
                end
            end
            irc_pkg::S_UB: begin
                if (i_stat.lo_lt_hi) begin
                    n_state = irc_pkg::S_UB_CMP;
                end else begin
                    o_cmd.ub_done = 1'b1;
                    n_state = irc_pkg::S_LB;
                end
            end
            irc_pkg::S_UB_CMP: begin
                o_cmd.ub_step = 1'b1;
                n_state = irc_pkg::S_UB;
            end
            irc_pkg::S_LB: begin
                if (i_stat.lo_lt_hi) begin
                    n_state = irc_pkg::S_LB_CMP;
                end else if (i_stat.si_neg || i_stat.li_ge_n
                             || !(i_stat.li_eq_si || i_stat.li_eq_si1)) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_loc = irc_pkg::LOC_BORDER;
                    n_state = irc_pkg::S_OUT;
                end else begin
                    o_cmd.rd_sel = irc_pkg::RD_LI;
                    n_state = irc_pkg::S_Q_LI;
                end
            end
            irc_pkg::S_LB_CMP: begin
                o_cmd.lb_step = 1'b1;
                n_state = irc_pkg::S_LB;
            end
            irc_pkg::S_Q_LI: begin
                if (i_stat.li_eq_si) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_loc = i_stat.ins_border ? irc_pkg::LOC_BORDER
                                                      : irc_pkg::LOC_INSIDE;
                    n_state = irc_pkg::S_OUT;
                end else begin
                    o_cmd.latch_li = 1'b1;
                    o_cmd.rd_sel = irc_pkg::RD_SI;
                    n_state = irc_pkg::S_Q_SI;
                end
            end
            irc_pkg::S_Q_SI: begin
                o_cmd.res_set = 1'b1;
                o_cmd.res_loc = i_stat.gap_out ? irc_pkg::LOC_OUTSIDE
                                               : irc_pkg::LOC_BORDER;
                n_state = irc_pkg::S_OUT;
            end
            irc_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state = irc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = irc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/irc_datapath.sv =====
module irc_datapath #(
    parameter int NUM_CONTIGS = 32,
    parameter int INTERVALS_PER_CONTIG = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  irc_pkg::t_cmd              i_cmd,
    output irc_pkg::t_stat             o_stat,
    input  logic [1:0]                 i_op,
    input  logic [4:0]                 i_contig_id,
    input  logic [irc_pkg::POS_W-1:0]  i_pos_start,
    input  logic [irc_pkg::POS_W-1:0]  i_pos_stop,
    input  logic                       i_is_insertion,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_location,
    output logic [2:0]                 o_status,
    output logic [irc_pkg::COV_W-1:0]  o_covered_size
);

    localparam int IW = (INTERVALS_PER_CONTIG > 1) ? $clog2(INTERVALS_PER_CONTIG) : 1;
    localparam int NW = $clog2(INTERVALS_PER_CONTIG + 1);
    localparam int SW = NW + 1;
    localparam int CW = (NUM_CONTIGS > 1) ? $clog2(NUM_CONTIGS) : 1;
    localparam int DEPTH = NUM_CONTIGS * INTERVALS_PER_CONTIG;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = irc_pkg::POS_W;
    localparam int KW = irc_pkg::COV_W;

    logic [PW-1:0] mem_start [DEPTH];
    logic [PW-1:0] mem_stop  [DEPTH];

    logic [NW-1:0] r_count [NUM_CONTIGS];
    logic [KW-1:0] r_cov;

    logic [1:0]    r_op;
    logic [4:0]    r_ctg;
    logic [PW-1:0] r_start;
    logic [PW-1:0] r_stop;
    logic          r_ins;
    logic [PW-1:0] r_rd_start;
    logic [PW-1:0] r_rd_stop;
    logic [PW-1:0] r_st_li;
    logic [NW-1:0] r_lo;
    logic [NW-1:0] r_hi;
    logic [NW-1:0] r_ub;
    logic [1:0]    r_res_loc;
    logic [2:0]    r_res_status;

    logic          r_out_valid;
    logic [1:0]    r_out_loc;
    logic [2:0]    r_out_status;
    logic [KW-1:0] r_out_cov;

    logic          ctg_bad;
    logic [CW-1:0] ctg_idx;
    logic [NW-1:0] n;
    logic [SW-1:0] mid_w;
    logic [NW-1:0] mid;
    logic [IW-1:0] idx;
    logic [AW-1:0] base;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [KW:0]   cov_sum;

    assign ctg_bad = (32'(r_ctg) >= NUM_CONTIGS);
    assign ctg_idx = CW'(r_ctg);
    assign n = ctg_bad ? '0 : r_count[ctg_idx];
    assign mid_w = (SW'(r_lo) + SW'(r_hi)) >> 1;
    assign mid = mid_w[NW-1:0];
    assign base = AW'(ctg_idx) * AW'(INTERVALS_PER_CONTIG);
    assign cov_sum = (KW+1)'(r_cov) + (KW+1)'(r_stop - r_start);

    always_comb begin
        case (i_cmd.rd_sel)
            irc_pkg::RD_ZERO: idx = '0;
            irc_pkg::RD_LAST: idx = IW'(n - NW'(1));
            irc_pkg::RD_LI:   idx = IW'(r_lo);
            irc_pkg::RD_SI:   idx = IW'(r_ub - NW'(1));
            default:          idx = IW'(mid);
        endcase
    end

    assign rd_addr = base + AW'(idx);
    assign wr_addr = base + AW'(n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem_start[wr_addr] <= r_start;
            mem_stop[wr_addr]  <= r_stop;
        end
        r_rd_start <= mem_start[rd_addr];
        r_rd_stop  <= mem_stop[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CONTIGS; k++) begin
                r_count[k] <= '0;
            end
            r_cov <= '0;
        end else if (i_cmd.clear) begin
            for (int k = 0; k < NUM_CONTIGS; k++) begin
                r_count[k] <= '0;
            end
            r_cov <= '0;
        end else if (i_cmd.write) begin
            r_count[ctg_idx] <= n + NW'(1);
            r_cov <= cov_sum[KW] ? {KW{1'b1}} : cov_sum[KW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_ctg   <= i_contig_id;
            r_start <= i_pos_start;
            r_stop  <= i_pos_stop;
            r_ins   <= i_is_insertion;
        end
        if (i_cmd.init_search) begin
            r_lo <= '0;
            r_hi <= n;
        end else if (i_cmd.ub_done) begin
            r_ub <= r_lo;
            r_lo <= '0;
            r_hi <= n;
        end else if (i_cmd.ub_step) begin
            if (r_rd_start <= r_start) begin
                r_lo <= mid + NW'(1);
            end else begin
                r_hi <= mid;
            end
        end else if (i_cmd.lb_step) begin
            if (r_rd_stop < r_stop) begin
                r_lo <= mid + NW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.latch_li) begin
            r_st_li <= r_rd_start;
        end
        if (i_cmd.res_set) begin
            r_res_loc    <= i_cmd.res_loc;
            r_res_status <= i_cmd.res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_loc    <= r_res_loc;
            r_out_status <= r_res_status;
            r_out_cov    <= r_cov;
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.flipped    = (r_stop < r_start);
        o_stat.zero       = (r_stop == r_start);
        o_stat.ctg_bad    = ctg_bad;
        o_stat.n_zero     = (n == '0);
        o_stat.full       = (32'(n) >= INTERVALS_PER_CONTIG);
        o_stat.unsorted   = (r_stop < r_rd_start);
        o_stat.overlap    = (r_start < r_rd_stop);
        o_stat.abut       = (r_rd_stop == r_start);
        o_stat.first_out  = (r_stop <= r_rd_start);
        o_stat.last_out   = (r_start >= r_rd_stop);
        o_stat.lo_lt_hi   = (r_lo < r_hi);
        o_stat.si_neg     = (r_ub == '0);
        o_stat.li_ge_n    = (r_lo >= n);
        o_stat.li_eq_si   = ((r_lo + NW'(1)) == r_ub);
        o_stat.li_eq_si1  = (r_lo == r_ub);
        o_stat.ins_border = r_ins && (r_start == (r_rd_stop - PW'(1)));
        o_stat.gap_out    = (r_start >= r_rd_stop) && (r_stop <= r_st_li);
        o_stat.out_free   = !r_out_valid || !i_stall;
    end

    assign o_valid        = r_out_valid;
    assign o_location     = r_out_loc;
    assign o_status       = r_out_status;
    assign o_covered_size = r_out_cov;

endmodule

// ===== src/interval_region_classifier_top.sv =====
// Interval region classifier. Holds up to INTERVALS_PER_CONTIG sorted half-open
// intervals for each of NUM_CONTIGS contigs and answers one result per request.
// A query that its contig's first and last intervals do not settle runs two
// binary searches of ceil(log2(n+1)) steps each over the contig's n intervals,
// reading the interval memories through their single read port. One request is
// worked on at a time, and a finished result waits in the output register while
// the next request is taken. Interval memories hold no reset value; counts and
// the covered total clear at reset.
module interval_region_classifier_top #(
    parameter int NUM_CONTIGS = 32,
    parameter int INTERVALS_PER_CONTIG = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_op,
    input  logic [4:0]                i_contig_id,
    input  logic [irc_pkg::POS_W-1:0] i_pos_start,
    input  logic [irc_pkg::POS_W-1:0] i_pos_stop,
    input  logic                      i_is_insertion,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_location,
    output logic [2:0]                o_status,
    output logic [irc_pkg::COV_W-1:0] o_covered_size
);

    irc_pkg::t_cmd  cmd;
    irc_pkg::t_stat stat;

    irc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    irc_datapath #(
        .NUM_CONTIGS          (NUM_CONTIGS),
        .INTERVALS_PER_CONTIG (INTERVALS_PER_CONTIG)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_contig_id    (i_contig_id),
        .i_pos_start    (i_pos_start),
        .i_pos_stop     (i_pos_stop),
        .i_is_insertion (i_is_insertion),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_location     (o_location),
        .o_status       (o_status),
        .o_covered_size (o_covered_size)
    );

endmodule

// ===== src/irc_checker.sv =====
`include "interval_region_classifier_top_defines.svh"

module irc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [1:0]                o_location,
    input logic [2:0]                o_status,
    input logic [irc_pkg::COV_W-1:0] o_covered_size
);

    `IRC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    `IRC_ASSERT_NEXT(a_cov_hold, o_valid && i_stall, $stable(o_covered_size))
    `IRC_ASSERT_NOW(a_loc_ok, o_valid && (o_location != irc_pkg::LOC_INSIDE), o_status == irc_pkg::ST_OK)
    `IRC_ASSERT_ALWAYS(a_rst_clear, !i_rst_n, !o_valid && !o_stall)

endmodule

bind interval_region_classifier_top irc_checker u_irc_checker (.*);
